FILE: rtl/flm_pkg.sv
// Shared types and constants of the fan load monitor.
// No dependencies; imported by fan_load_monitor, its checker and its testbench.
package flm_pkg;

   typedef enum logic [1:0] {
      OP_SET_PERCENT = 2'd0,
      OP_TICK        = 2'd1,
      OP_EVALUATE    = 2'd2,
      OP_IDLE_OP     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_PWM_OK        = 3'd0,
      CSR_MIN_PERCENT   = 3'd1,
      CSR_SETTLE_MS     = 3'd2,
      CSR_RATED_POWER   = 3'd3,
      CSR_MAX_PODS      = 3'd4,
      CSR_CURRENT_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

   localparam int MUL_STEPS   = 16;
   localparam int DIV_STEPS   = 5;
   localparam int PERCENT_MAX = 100;

   localparam logic        PWM_OK_RST        = 1'b1;
   localparam logic [6:0]  MIN_PERCENT_RST   = 7'd30;
   localparam logic [15:0] SETTLE_MS_RST     = 16'd2000;
   localparam logic [15:0] RATED_POWER_RST   = 16'd1000;
   localparam logic [3:0]  MAX_PODS_RST      = 4'd8;
   localparam logic [14:0] CURRENT_LIMIT_RST = 15'd1000;

endpackage

FILE: rtl/fan_load_monitor.sv
// Fan duty control with a load-count estimator, bit-serial multiply and divide; uses flm_pkg.
// Sequence: set percent, tick, unused opcodes and evaluates without a valid estimate go
// from acceptance straight to the finish state; a valid estimate first runs 16 multiply
// steps, 1 setup, 5 restoring divide steps, 1 finish. One request is in flight at a time,
// so a new request is taken only once the last result is loaded, which waits on rsp_ready.
// Reset (synchronous): registers take their defaults, percent and settle counter clear.
module fan_load_monitor
   import flm_pkg::*;
#(
   parameter int DUTY_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_percent_request,
   input  logic signed [15:0] req_current_ma,
   input  logic [15:0]        req_supply_mv,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_duty,
   output logic               rsp_estimate_valid,
   output logic [3:0]         rsp_pod_count,
   output logic               rsp_pod_limit_exceeded,
   output logic               rsp_absolute_limit_exceeded,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int DUTY_FULL = (1 << DUTY_BITS) - 1;

   // duty for every percent code
   logic [7:0] duty_table [128];
   for (genvar g = 0; g < 128; g++) begin : g_duty
      assign duty_table[g] = 8'((DUTY_FULL * g) / PERCENT_MAX);
   end

   state_type state_ff, state_in;

   logic        pwm_ok_ff;
   logic [6:0]  min_percent_ff;
   logic [15:0] settle_ms_ff;
   logic [15:0] rated_power_ff;
   logic [3:0]  max_pods_ff;
   logic [14:0] current_limit_ff;

   logic [6:0]  fan_percent_ff;
   logic [15:0] settle_elapsed_ff;

   logic [15:0] mv_sr_ff;
   logic [15:0] rated_sr_ff;
   logic [38:0] a_sr_ff;
   logic [32:0] c_sr_ff;
   logic [38:0] acc_n_ff;
   logic [32:0] acc_d_ff;
   logic [38:0] rem_ff;
   logic [38:0] dsr_ff;
   logic [4:0]  quo_ff;
   logic [3:0]  cnt_ff;
   logic        n_zero_ff;

   logic        est_ok_ff;
   logic        pod_lim_ff;
   logic        abs_lim_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_duty_ff;
   logic        rsp_est_ff;
   logic [3:0]  rsp_count_ff;
   logic        rsp_pod_lim_ff;
   logic        rsp_abs_lim_ff;

   logic        accept;
   logic        out_free;
   logic        load_rsp;
   opcode_type  op;

   logic [6:0]  clamp_pct;
   logic        cur_ok;
   logic [14:0] ima;
   logic        eval_gate;
   logic        est_gate;
   logic [21:0] cur_scaled;
   logic [21:0] lim_scaled;
   logic [39:0] diff;
   logic [38:0] n_sum;
   logic [3:0]  final_count;

   assign op       = opcode_type'(req_opcode);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   always_comb begin
      if (req_percent_request[15]) begin
         clamp_pct = 7'd0;
      end else if (req_percent_request > 16'sd100) begin
         clamp_pct = 7'(PERCENT_MAX);
      end else begin
         clamp_pct = req_percent_request[6:0];
      end
   end

   assign cur_ok     = !req_current_ma[15];
   assign ima        = req_current_ma[14:0];
   assign eval_gate  = pwm_ok_ff && cur_ok;
   assign est_gate   = eval_gate && (fan_percent_ff >= min_percent_ff)
                       && (settle_elapsed_ff >= settle_ms_ff) && (req_supply_mv != 16'd0);
   assign cur_scaled = 22'(ima) * 22'd100;
   assign lim_scaled = 22'(current_limit_ff) * 22'(fan_percent_ff);

   assign diff  = {1'b0, rem_ff} - {1'b0, dsr_ff};
   assign n_sum = acc_n_ff + 39'(acc_d_ff);

   always_comb begin
      if (n_zero_ff) begin
         final_count = 4'd0;
      end else if (quo_ff[4] || (quo_ff[3:0] > max_pods_ff)) begin
         final_count = max_pods_ff;
      end else begin
         final_count = quo_ff[3:0];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = (op == OP_EVALUATE && est_gate) ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            if (cnt_ff == 4'(MUL_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_ok_ff        <= PWM_OK_RST;
         min_percent_ff   <= MIN_PERCENT_RST;
         settle_ms_ff     <= SETTLE_MS_RST;
         rated_power_ff   <= RATED_POWER_RST;
         max_pods_ff      <= MAX_PODS_RST;
         current_limit_ff <= CURRENT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PWM_OK:        pwm_ok_ff        <= csr_wdata[0];
            CSR_MIN_PERCENT:   min_percent_ff   <= csr_wdata[6:0];
            CSR_SETTLE_MS:     settle_ms_ff     <= csr_wdata;
            CSR_RATED_POWER:   rated_power_ff   <= csr_wdata;
            CSR_MAX_PODS:      max_pods_ff      <= csr_wdata[3:0];
            CSR_CURRENT_LIMIT: current_limit_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // fan percent and settle counter
   always_ff @(posedge clock) begin
      if (reset) begin
         fan_percent_ff    <= 7'd0;
         settle_elapsed_ff <= 16'd0;
      end else if (accept) begin
         case (op)
            OP_SET_PERCENT: begin
               if (clamp_pct != fan_percent_ff) begin
                  settle_elapsed_ff <= 16'd0;
               end
               fan_percent_ff <= pwm_ok_ff ? clamp_pct : 7'd0;
            end
            OP_TICK: begin
               if (settle_elapsed_ff != 16'hFFFF) begin
                  settle_elapsed_ff <= settle_elapsed_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath: flags at accept, bit-serial multiply, restoring divide
   always_ff @(posedge clock) begin
      if (accept) begin
         est_ok_ff   <= (op == OP_EVALUATE) && est_gate;
         abs_lim_ff  <= (op == OP_EVALUATE) && eval_gate && (ima > current_limit_ff);
         pod_lim_ff  <= (op == OP_EVALUATE) && eval_gate
                        && (fan_percent_ff >= min_percent_ff) && (cur_scaled > lim_scaled);
         mv_sr_ff    <= req_supply_mv;
         rated_sr_ff <= rated_power_ff;
         a_sr_ff     <= 39'(ima) * 39'd200;
         c_sr_ff     <= 33'(fan_percent_ff) * 33'd1000;
         acc_n_ff    <= '0;
         acc_d_ff    <= '0;
         cnt_ff      <= '0;
      end
      unique case (state_ff)
         ST_MUL: begin
            if (mv_sr_ff[0]) begin
               acc_n_ff <= acc_n_ff + a_sr_ff;
            end
            if (rated_sr_ff[0]) begin
               acc_d_ff <= acc_d_ff + c_sr_ff;
            end
            mv_sr_ff    <= mv_sr_ff >> 1;
            rated_sr_ff <= rated_sr_ff >> 1;
            a_sr_ff     <= a_sr_ff << 1;
            c_sr_ff     <= c_sr_ff << 1;
            cnt_ff      <= (cnt_ff == 4'(MUL_STEPS - 1)) ? 4'd0 : cnt_ff + 4'd1;
         end
         ST_PREP: begin
            rem_ff    <= n_sum;
            dsr_ff    <= 39'(acc_d_ff) << 5;
            n_zero_ff <= (n_sum == 39'd0);
            quo_ff    <= '0;
         end
         ST_DIV: begin
            // keep the difference when the shifted divisor fits
            if (!diff[39]) begin
               rem_ff <= diff[38:0];
            end
            quo_ff <= {quo_ff[3:0], !diff[39]};
            dsr_ff <= dsr_ff >> 1;
            cnt_ff <= cnt_ff + 4'd1;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_duty_ff    <= duty_table[fan_percent_ff];
         rsp_est_ff     <= est_ok_ff;
         rsp_count_ff   <= est_ok_ff ? final_count : 4'd0;
         rsp_pod_lim_ff <= pod_lim_ff;
         rsp_abs_lim_ff <= abs_lim_ff;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_duty                    = rsp_duty_ff;
   assign rsp_estimate_valid          = rsp_est_ff;
   assign rsp_pod_count               = rsp_count_ff;
   assign rsp_pod_limit_exceeded      = rsp_pod_lim_ff;
   assign rsp_absolute_limit_exceeded = rsp_abs_lim_ff;

   a_count_needs_estimate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_count_ff != 4'd0) |-> rsp_est_ff)
      else $error("pod count without a valid estimate");

   a_one_request_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_divide_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < 4'(DIV_STEPS))
      else $error("divide step count overran");

   a_result_load_safe: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

FILE: verif/fan_load_monitor_checker.sv
// Result checker for fan_load_monitor: follows register writes and requests, predicts
// each result and compares it field by field with what the block returns.
// Depends on flm_pkg.
module fan_load_monitor_checker
   import flm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_percent_request,
   input  logic signed [15:0] req_current_ma,
   input  logic [15:0]        req_supply_mv,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_duty,
   input  logic               rsp_estimate_valid,
   input  logic [3:0]         rsp_pod_count,
   input  logic               rsp_pod_limit_exceeded,
   input  logic               rsp_absolute_limit_exceeded,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 mismatch_count,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned DUTY_FULL = (64'd1 << 8) - 1;

   typedef struct packed {
      logic [7:0] duty;
      logic       estimate_valid;
      logic [3:0] pod_count;
      logic       pod_over;
      logic       abs_over;
   } fan_result_type;

   logic        pwm_ok_reg;
   logic [6:0]  min_percent_reg;
   logic [15:0] settle_ms_reg;
   logic [15:0] rated_mw_reg;
   logic [3:0]  max_pods_reg;
   logic [14:0] current_limit_reg;

   logic [6:0]  fan_pct;
   logic [15:0] settle_count;

   fan_result_type results_due[$];

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t fan_load_monitor mismatch: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advance the percent/settle state by one request and return the result it yields.
   function automatic fan_result_type compute_fan_result(opcode_type op,
         logic signed [15:0] pct_req, logic signed [15:0] cur_ma, logic [15:0] supply);
      fan_result_type r;
      logic [6:0] clamped;
      longint unsigned cur_u, power_num, power_den, est;
      r = '0;
      case (op)
         OP_SET_PERCENT: begin
            if (pct_req < 0)
               clamped = 7'd0;
            else if (pct_req > PERCENT_MAX)
               clamped = 7'(PERCENT_MAX);
            else
               clamped = pct_req[6:0];
            // compare the clamped request, not the stored value, against the old percent
            if (clamped != fan_pct)
               settle_count = 16'd0;
            fan_pct = pwm_ok_reg ? clamped : 7'd0;
         end
         OP_TICK: begin
            if (settle_count != 16'hFFFF)
               settle_count = settle_count + 16'd1;
         end
         OP_EVALUATE: begin
            if (pwm_ok_reg && cur_ma >= 0) begin
               cur_u = {49'd0, cur_ma[14:0]};
               r.abs_over = cur_u > current_limit_reg;
               if (fan_pct >= min_percent_reg) begin
                  r.pod_over = cur_u * 100 > longint'(current_limit_reg) * fan_pct;
                  if (settle_count >= settle_ms_reg && supply != 16'd0) begin
                     power_num = longint'(supply) * cur_u * 100;
                     power_den = longint'(fan_pct) * rated_mw_reg * 1000;
                     if (power_den == 0)
                        est = (power_num > 0) ? max_pods_reg : 0;
                     else
                        est = (2 * power_num + power_den) / (2 * power_den);
                     if (est > max_pods_reg)
                        est = max_pods_reg;
                     r.pod_count = est[3:0];
                     r.estimate_valid = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.duty = 8'((DUTY_FULL * fan_pct) / 100);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fan_result_type want;
      if (reset) begin
         pwm_ok_reg = PWM_OK_RST;
         min_percent_reg = MIN_PERCENT_RST;
         settle_ms_reg = SETTLE_MS_RST;
         rated_mw_reg = RATED_POWER_RST;
         max_pods_reg = MAX_PODS_RST;
         current_limit_reg = CURRENT_LIMIT_RST;
         fan_pct = 7'd0;
         settle_count = 16'd0;
         results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PWM_OK:        pwm_ok_reg = csr_wdata[0];
               CSR_MIN_PERCENT:   min_percent_reg = csr_wdata[6:0];
               CSR_SETTLE_MS:     settle_ms_reg = csr_wdata;
               CSR_RATED_POWER:   rated_mw_reg = csr_wdata;
               CSR_MAX_PODS:      max_pods_reg = csr_wdata[3:0];
               CSR_CURRENT_LIMIT: current_limit_reg = csr_wdata[14:0];
               default: ;
            endcase
         end
         // retire first, so a new request never pairs with a result in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with no request pending", rsp_duty, 16'd0);
            end else begin
               want = results_due.pop_front();
               if (rsp_duty !== want.duty)
                  report_mismatch("duty", rsp_duty, want.duty);
               if (rsp_estimate_valid !== want.estimate_valid)
                  report_mismatch("estimate_valid", rsp_estimate_valid, want.estimate_valid);
               if (rsp_pod_count !== want.pod_count)
                  report_mismatch("pod_count", rsp_pod_count, want.pod_count);
               if (rsp_pod_limit_exceeded !== want.pod_over)
                  report_mismatch("pod_limit_exceeded", rsp_pod_limit_exceeded,
                                  want.pod_over);
               if (rsp_absolute_limit_exceeded !== want.abs_over)
                  report_mismatch("absolute_limit_exceeded", rsp_absolute_limit_exceeded,
                                  want.abs_over);
            end
         end
         if (req_valid && req_ready)
            results_due.push_back(compute_fan_result(opcode_type'(req_opcode),
                  req_percent_request, req_current_ma, req_supply_mv));
      end
      outstanding <= results_due.size();
   end

endmodule

FILE: verif/fan_load_monitor_tb.sv
// Testbench top for fan_load_monitor: clock, reset, register settings and request traffic.
// Instantiates the block and fan_load_monitor_checker; depends on flm_pkg.
module fan_load_monitor_tb
   import flm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_STALL = 300;
   localparam int PHASE_ITEMS = 180;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = OP_TICK;
   logic signed [15:0] req_percent_request = '0;
   logic signed [15:0] req_current_ma = '0;
   logic [15:0]        req_supply_mv = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_duty;
   logic               rsp_estimate_valid;
   logic [3:0]         rsp_pod_count;
   logic               rsp_pod_limit_exceeded;
   logic               rsp_absolute_limit_exceeded;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = CSR_PWM_OK;
   logic [15:0]        csr_wdata = '0;

   int mismatch_count;
   int outstanding;

   int sender_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stalls_asked = 0;
   int stalls_served = 0;
   int stall_left = 0;
   int min_now = 30;
   int settle_now = 2000;
   int limit_now = 1000;
   int last_percent = 0;

   fan_load_monitor u_top (.*);

   fan_load_monitor_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random back-pressure, plus a long hold-off when asked
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_served != stalls_asked) begin
         rsp_ready <= 1'b0;
         stall_left <= LONG_STALL;
         stalls_served <= stalls_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("[fan_load_monitor] ERROR");
      $finish;
   end

   task automatic send_request(opcode_type op, logic [15:0] pct, logic [15:0] cur,
                               logic [15:0] mv);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_percent_request <= pct;
      req_current_ma <= cur;
      req_supply_mv <= mv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write every register; bits above each register's width carry junk that must be dropped.
   task automatic apply_settings(int pwm, int minp, int settle, int rated, int maxp, int limit);
      wait_drained();
      write_csr(CSR_PWM_OK, (16'($urandom) & 16'hFFFE) | 16'(pwm));
      write_csr(CSR_MIN_PERCENT, (16'($urandom) & 16'hFF80) | 16'(minp));
      write_csr(CSR_SETTLE_MS, 16'(settle));
      write_csr(CSR_RATED_POWER, 16'(rated));
      write_csr(CSR_MAX_PODS, (16'($urandom) & 16'hFFF0) | 16'(maxp));
      write_csr(CSR_CURRENT_LIMIT, (16'($urandom) & 16'h8000) | 16'(limit));
      write_csr(CSR_SPARE_LO, 16'($urandom));
      write_csr(CSR_SPARE_HI, 16'($urandom));
      csr_we <= 1'b0;
      min_now = minp;
      settle_now = settle;
      limit_now = limit;
   endtask

   function automatic logic [15:0] pick_current();
      int r;
      int hi;
      r = $urandom_range(99);
      hi = (2 * limit_now + 20 > 32767) ? 32767 : 2 * limit_now + 20;
      if (r < 10)
         return 16'($urandom);
      if (r < 15)
         return 16'(-$urandom_range(1, 2000));
      return 16'($urandom_range(0, hi));
   endfunction

   function automatic logic [15:0] pick_supply();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 16'd0;
      if (r < 20)
         return 16'($urandom);
      return 16'($urandom_range(1000, 15000));
   endfunction

   // Mostly set / settle / evaluate runs with random content, the rest single noise requests.
   task automatic run_session(int n_items);
      int sent;
      int ticks;
      int pct;
      int r;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            r = $urandom_range(99);
            if (r < 25)
               pct = last_percent;
            else if (r < 40)
               pct = $urandom_range(min_now, 100);
            else
               pct = $urandom_range(0, 100);
            send_request(OP_SET_PERCENT, 16'(pct), 16'($urandom), 16'($urandom));
            last_percent = pct;
            ticks = $urandom_range(0, settle_now + 3);
            repeat (ticks) send_request(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
            sent += 1 + ticks;
            repeat ($urandom_range(1, 6)) begin
               send_request(OP_EVALUATE, 16'($urandom), pick_current(), pick_supply());
               sent++;
               if ($urandom_range(3) == 0) begin
                  send_request(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
                  sent++;
               end
            end
         end else begin
            send_request(opcode_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         16'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: percent 0 is below the minimum, only the raw current flag can rise
      send_request(OP_EVALUATE, 16'd0, 16'd1500, 16'd12000);
      send_request(OP_TICK, 16'd0, 16'd0, 16'd0);

      apply_settings(1, 0, 0, 1000, 15, 1000);
      // zero denominator at percent 0: zero product gives 0, nonzero saturates
      send_request(OP_EVALUATE, 16'd0, 16'd0, 16'd12000);
      send_request(OP_EVALUATE, 16'd0, 16'd100, 16'd12000);
      send_request(OP_EVALUATE, 16'd0, 16'd100, 16'd0);
      send_request(OP_EVALUATE, 16'd0, 16'hFFFF, 16'd12000);
      send_request(OP_EVALUATE, 16'hFFFF, 16'h8000, 16'hFFFF);
      send_request(OP_SET_PERCENT, 16'h8000, 16'd0, 16'd0);
      send_request(OP_SET_PERCENT, 16'h7FFF, 16'd0, 16'd0);
      send_request(OP_EVALUATE, 16'd0, 16'h7FFF, 16'hFFFF);
      send_request(OP_SET_PERCENT, 16'd101, 16'd0, 16'd0);
      send_request(OP_SET_PERCENT, 16'hFFFF, 16'd0, 16'd0);
      send_request(OP_SET_PERCENT, 16'd100, 16'd0, 16'd0);
      send_request(OP_SET_PERCENT, 16'd50, 16'd0, 16'd0);
      send_request(OP_TICK, 16'd0, 16'd0, 16'd0);
      send_request(OP_IDLE_OP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // half-up rounding: 2.5 goes to 3, 2.49 to 2
      send_request(OP_EVALUATE, 16'd0, 16'd100, 16'd12500);
      send_request(OP_EVALUATE, 16'd0, 16'd100, 16'd12450);
      // limit boundaries: equal is not over
      send_request(OP_EVALUATE, 16'd0, 16'd500, 16'd12000);
      send_request(OP_EVALUATE, 16'd0, 16'd501, 16'd1);
      send_request(OP_EVALUATE, 16'd0, 16'd1000, 16'hFFFF);
      send_request(OP_EVALUATE, 16'd0, 16'd1001, 16'd12000);

      // PWM unavailable: percent forced to 0, evaluate flags nothing
      apply_settings(0, 0, 0, 1000, 15, 1000);
      send_request(OP_SET_PERCENT, 16'd70, 16'd0, 16'd0);
      send_request(OP_EVALUATE, 16'd0, 16'd2000, 16'd12000);
      send_request(OP_TICK, 16'd0, 16'd0, 16'd0);
      send_request(OP_SET_PERCENT, 16'hFFFB, 16'd0, 16'd0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin
               sender_idle_pct = 7;
               rsp_idle_pct = 46;
            end
            1: begin
               sender_idle_pct = 46;
               rsp_idle_pct = 7;
            end
            default: begin
               sender_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (ph)
            0: apply_settings(1, 30, 3, 1000, 8, 1000);
            1: apply_settings(1, 0, 0, 1, 15, 32767);
            2: apply_settings(1, 100, 10, 65535, 0, 0);
            3: apply_settings(0, 50, 2, 500, 4, 500);
            4: apply_settings(1, $urandom_range(0, 100), $urandom_range(0, 12),
                              $urandom_range(200, 3000), $urandom_range(0, 15),
                              $urandom_range(0, 32767));
            default: apply_settings($urandom_range(0, 1), $urandom_range(0, 100),
                                    $urandom_range(0, 12), $urandom_range(1, 65535),
                                    $urandom_range(0, 15), $urandom_range(0, 32767));
         endcase
         if (ph == 1)
            stalls_asked++;
         if (ph == 3) begin
            run_session(PHASE_ITEMS / 2);
            wait_drained();
            run_session(PHASE_ITEMS / 2);
         end else begin
            run_session(PHASE_ITEMS);
         end
      end

      req_valid <= 1'b0;
      for (k = 0; k < 5000 && outstanding != 0; k++) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("[fan_load_monitor] OK");
      else
         $display("[fan_load_monitor] ERROR");
      $finish;
   end

endmodule
